// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property
`define ACBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same-cycle implication
`define ACBF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/acbf_pkg.sv =====
// ----------------------------------------------------------------------------
// acbf_pkg
// Shared types and codes of the ancestor counting Bloom filter.
// ----------------------------------------------------------------------------
package acbf_pkg;

	localparam int TABLE_BITS_DEF       = 12;
	localparam int COUNT_WIDTH_DEF      = 16;
	localparam int MAX_DEPTH_DEF        = 64;
	localparam int MAX_FRAME_HASHES_DEF = 32;

	localparam int OP_W        = 3;
	localparam int HASH_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_OUT_W = 7;

	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
	localparam logic [OP_W-1:0] OP_POP   = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FRAME_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [HASH_W-1:0] hash;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic                   reject;
		logic                   query_done;
		logic [DEPTH_OUT_W-1:0] depth;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_LEN,
		S_POP_LEN,
		S_POP_HASH,
		S_QUERY,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		TC_NONE,
		TC_READ,
		TC_INC,
		TC_DEC,
		TC_ZERO
	} tbl_cmd_t;

	typedef struct packed {
		logic len_rd;
		logic len_we;
		logic slot_rd;
		logic slot_we;
	} fs_ctrl_t;

endpackage

// ===== rtl/core/acbf_count_table.sv =====
// ----------------------------------------------------------------------------
// acbf_count_table
// Saturating counter table: synchronous RAM with read-modify-write and
// write-back forwarding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acbf_count_table #(
	parameter int TABLE_BITS  = acbf_pkg::TABLE_BITS_DEF,
	parameter int COUNT_WIDTH = acbf_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acbf_pkg::tbl_cmd_t     cmd,
	input  logic [TABLE_BITS-1:0]  addr,
	output logic [COUNT_WIDTH-1:0] rdata
);
	import acbf_pkg::*;

	localparam int ENTRIES = 2 ** TABLE_BITS;

	logic [COUNT_WIDTH-1:0] mem [ENTRIES];

	logic [COUNT_WIDTH-1:0] rd_s1;
	logic [COUNT_WIDTH-1:0] wb_s1;
	logic [COUNT_WIDTH-1:0] base;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic [TABLE_BITS-1:0]  addr_s1;
	logic [TABLE_BITS-1:0]  wr_addr;
	tbl_cmd_t               cmd_s1;
	logic                   fwd_s1;
	logic                   wr_en;
	logic                   rd_en;

	assign rd_en = (cmd == TC_READ) || (cmd == TC_INC) || (cmd == TC_DEC);
	assign base  = fwd_s1 ? wb_s1 : rd_s1;
	assign rdata = base;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = base;
		unique case (cmd_s1)
			TC_INC: begin
				wr_en   = 1'b1;
				wr_data = (&base) ? base : base + 1'b1;
			end
			TC_DEC: begin
				wr_en   = 1'b1;
				wr_data = (base == '0) ? base : base - 1'b1;
			end
			default: ;
		endcase
		if (cmd == TC_ZERO) begin
			wr_en   = 1'b1;
			wr_addr = addr;
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_s1 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		wb_s1   <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= TC_NONE;
			fwd_s1 <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			fwd_s1 <= rd_en && wr_en && (wr_addr == addr);
		end
	end

	`ACBF_ASSERT_IMPLY(a_zero_vs_wb, (cmd == TC_ZERO), !(cmd_s1 == TC_INC || cmd_s1 == TC_DEC), "clear sweep collides with write-back")
	`ACBF_ASSERT(a_rmw_writes, (cmd == TC_INC || cmd == TC_DEC) |=> wr_en, "read-modify-write lost its write-back")
	`ACBF_ASSERT(a_fwd_source, fwd_s1 |-> $past(wr_en), "forwarding without a write")

endmodule

// ===== rtl/core/acbf_frame_store.sv =====
// ----------------------------------------------------------------------------
// acbf_frame_store
// Frame lengths and per-frame table indices, two synchronous RAMs.
// ----------------------------------------------------------------------------
module acbf_frame_store #(
	parameter int TABLE_BITS       = acbf_pkg::TABLE_BITS_DEF,
	parameter int MAX_DEPTH        = acbf_pkg::MAX_DEPTH_DEF,
	parameter int MAX_FRAME_HASHES = acbf_pkg::MAX_FRAME_HASHES_DEF,
	parameter int FI               = $clog2(MAX_DEPTH),
	parameter int SI               = $clog2(MAX_FRAME_HASHES),
	parameter int LW               = $clog2(MAX_FRAME_HASHES + 1)
) (
	input  logic                  clk,
	input  acbf_pkg::fs_ctrl_t    ctrl,
	input  logic [FI-1:0]         frame,
	input  logic [SI-1:0]         slot,
	input  logic [LW-1:0]         len_wdata,
	input  logic [TABLE_BITS-1:0] slot_wdata,
	output logic [LW-1:0]         len_rdata,
	output logic [TABLE_BITS-1:0] slot_rdata
);
	import acbf_pkg::*;

	localparam int SLOTS = MAX_DEPTH * MAX_FRAME_HASHES;
	localparam int HA    = $clog2(SLOTS);

	logic [LW-1:0]         len_mem  [MAX_DEPTH];
	logic [TABLE_BITS-1:0] slot_mem [SLOTS];
	logic [HA-1:0]         slot_addr;

	assign slot_addr = HA'(frame) * HA'(MAX_FRAME_HASHES) + HA'(slot);

	always_ff @(posedge clk) begin
		if (ctrl.len_we)
			len_mem[frame] <= len_wdata;
		if (ctrl.len_rd)
			len_rdata <= len_mem[frame];
	end

	always_ff @(posedge clk) begin
		if (ctrl.slot_we)
			slot_mem[slot_addr] <= slot_wdata;
		if (ctrl.slot_rd)
			slot_rdata <= slot_mem[slot_addr];
	end

endmodule

// ===== rtl/core/ancestor_counting_bloom_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ancestor_counting_bloom_filter_unit: counting Bloom filter over ancestor frames
// Pop reads the frame length, then decrements the table entry of each hash in the frame.
// Pop of the last frame and clear sweep the whole table, one entry a cycle.
// The result beat comes in the same cycle that the next beat can be accepted. Reset async;
// then a table sweep with stall high. One beat in work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ancestor_counting_bloom_filter_unit #(
	parameter int TABLE_BITS       = acbf_pkg::TABLE_BITS_DEF,
	parameter int COUNT_WIDTH      = acbf_pkg::COUNT_WIDTH_DEF,
	parameter int MAX_DEPTH        = acbf_pkg::MAX_DEPTH_DEF,
	parameter int MAX_FRAME_HASHES = acbf_pkg::MAX_FRAME_HASHES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  acbf_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output acbf_pkg::result_t result
);
	import acbf_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int FI = $clog2(MAX_DEPTH);
	localparam int SI = $clog2(MAX_FRAME_HASHES);
	localparam int LW = $clog2(MAX_FRAME_HASHES + 1);

	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
	localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_FRAME_HASHES);

	state_t                 state_q, state_d;
	item_t                  item_q;
	logic [DW-1:0]          depth_q;
	logic [DW-1:0]          top_full;
	logic [FI-1:0]          top_idx;
	logic [LW-1:0]          len_q;
	logic [LW-1:0]          i_q;
	logic [TABLE_BITS-1:0]  clr_q;
	logic                   clr_item_q;
	logic                   clr_end;
	logic                   qdec_q, qrej_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   rej_q, done_q;
	logic                   result_valid_q;
	result_t                result_q;
	result_t                res_d;
	logic                   out_free;
	logic [DW+DEPTH_OUT_W-1:0] depth_ext;

	tbl_cmd_t               tcmd;
	logic [TABLE_BITS-1:0]  taddr;
	logic [COUNT_WIDTH-1:0] cnt_rd;

	fs_ctrl_t               fs;
	logic [FI-1:0]          fs_frame;
	logic [SI-1:0]          fs_slot;
	logic [LW-1:0]          len_wdata;
	logic [TABLE_BITS-1:0]  slot_wdata;
	logic [LW-1:0]          len_rd;
	logic [LW-1:0]          len_clamp;
	logic [TABLE_BITS-1:0]  slot_rd;

	acbf_count_table #(
		.TABLE_BITS (TABLE_BITS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (tcmd),
		.addr  (taddr),
		.rdata (cnt_rd)
	);

	acbf_frame_store #(
		.TABLE_BITS      (TABLE_BITS),
		.MAX_DEPTH       (MAX_DEPTH),
		.MAX_FRAME_HASHES(MAX_FRAME_HASHES),
		.FI              (FI),
		.SI              (SI),
		.LW              (LW)
	) u_frames (
		.clk       (clk),
		.ctrl      (fs),
		.frame     (fs_frame),
		.slot      (fs_slot),
		.len_wdata (len_wdata),
		.slot_wdata(slot_wdata),
		.len_rdata (len_rd),
		.slot_rdata(slot_rd)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign top_full  = depth_q - 1'b1;
	assign top_idx   = top_full[FI-1:0];
	assign len_clamp = (len_rd > LEN_MAX) ? LEN_MAX : len_rd;
	assign clr_end   = &clr_q;
	assign out_free  = !result_valid_q || !result_stall;
	assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_q};

	always_comb begin
		res_d.status     = status_q;
		res_d.reject     = rej_q;
		res_d.query_done = done_q;
		res_d.depth      = depth_ext[DEPTH_OUT_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:
				if (clr_end)
					state_d = clr_item_q ? S_OUT : S_IDLE;
			S_IDLE:
				if (item_valid) begin
					unique case (item.op)
						OP_ADD:
							state_d = (depth_q != '0 && item.hash != '0) ? S_ADD_LEN : S_OUT;
						OP_POP: begin
							if (depth_q == '0)
								state_d = S_OUT;
							else if (depth_q == DW'(1))
								state_d = S_CLEAR;
							else
								state_d = S_POP_LEN;
						end
						OP_QUERY:
							state_d = (!qdec_q && item.hash != '0) ? S_QUERY : S_OUT;
						OP_CLEAR:
							state_d = S_CLEAR;
						default:
							state_d = S_OUT;
					endcase
				end
			S_ADD_LEN:
				state_d = S_OUT;
			S_POP_LEN:
				state_d = (len_clamp == '0) ? S_OUT : S_POP_HASH;
			S_POP_HASH:
				if (i_q == len_q)
					state_d = S_OUT;
			S_QUERY:
				state_d = S_OUT;
			S_OUT:
				if (out_free)
					state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		tcmd       = TC_NONE;
		taddr      = item.hash[TABLE_BITS-1:0];
		fs         = '0;
		fs_frame   = top_idx;
		fs_slot    = '0;
		len_wdata  = '0;
		slot_wdata = item_q.hash[TABLE_BITS-1:0];
		unique case (state_q)
			S_CLEAR: begin
				tcmd  = TC_ZERO;
				taddr = clr_q;
			end
			S_IDLE:
				if (item_valid) begin
					unique case (item.op)
						OP_PUSH:
							if (depth_q < DEPTH_MAX) begin
								fs.len_we = 1'b1;
								fs_frame  = depth_q[FI-1:0];
							end
						OP_ADD:
							fs.len_rd = (depth_q != '0) && (item.hash != '0);
						OP_POP:
							fs.len_rd = (depth_q > DW'(1));
						OP_QUERY:
							if (!qdec_q && item.hash != '0)
								tcmd = TC_READ;
						default: ;
					endcase
				end
			S_ADD_LEN:
				if (len_rd < LEN_MAX) begin
					fs.slot_we = 1'b1;
					fs_slot    = len_rd[SI-1:0];
					fs.len_we  = 1'b1;
					len_wdata  = len_rd + 1'b1;
					tcmd       = TC_INC;
					taddr      = item_q.hash[TABLE_BITS-1:0];
				end
			S_POP_LEN:
				fs.slot_rd = (len_clamp != '0);
			S_POP_HASH: begin
				tcmd       = TC_DEC;
				taddr      = slot_rd;
				fs.slot_rd = (i_q != len_q);
				fs_slot    = i_q[SI-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			depth_q        <= '0;
			len_q          <= '0;
			i_q            <= '0;
			clr_q          <= '0;
			clr_item_q     <= 1'b0;
			qdec_q         <= 1'b0;
			qrej_q         <= 1'b0;
			status_q       <= ST_OK;
			rej_q          <= 1'b0;
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_end)
						clr_item_q <= 1'b0;
				end
				S_IDLE:
					if (item_valid) begin
						status_q <= ST_OK;
						rej_q    <= 1'b0;
						done_q   <= 1'b0;
						if (item.op != OP_QUERY) begin
							qdec_q <= 1'b0;
							qrej_q <= 1'b0;
						end
						unique case (item.op)
							OP_PUSH:
								if (depth_q < DEPTH_MAX)
									depth_q <= depth_q + 1'b1;
								else
									status_q <= ST_STACK_FULL;
							OP_ADD:
								if (depth_q == '0)
									status_q <= ST_NO_FRAME;
							OP_POP:
								if (depth_q == '0)
									status_q <= ST_NO_FRAME;
								else if (depth_q == DW'(1)) begin
									depth_q    <= '0;
									clr_item_q <= 1'b1;
								end
							OP_QUERY:
								if (qdec_q) begin
									rej_q <= qrej_q;
									if (item.last) begin
										qdec_q <= 1'b0;
										qrej_q <= 1'b0;
									end
								end else if (item.hash == '0) begin
									done_q <= 1'b1;
									qdec_q <= !item.last;
									qrej_q <= 1'b0;
								end
							OP_CLEAR: begin
								depth_q    <= '0;
								clr_item_q <= 1'b1;
							end
							default: ;
						endcase
					end
				S_ADD_LEN:
					if (len_rd >= LEN_MAX)
						status_q <= ST_FRAME_FULL;
				S_POP_LEN: begin
					len_q <= len_clamp;
					i_q   <= LW'(1);
					if (len_clamp == '0)
						depth_q <= top_full;
				end
				S_POP_HASH:
					if (i_q != len_q)
						i_q <= i_q + 1'b1;
					else
						depth_q <= top_full;
				S_QUERY:
					if (cnt_rd == '0) begin
						rej_q  <= 1'b1;
						done_q <= 1'b1;
						qdec_q <= !item_q.last;
						qrej_q <= !item_q.last;
					end else begin
						done_q <= item_q.last;
					end
				default: ;
			endcase
			if (state_q == S_OUT && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid)
			item_q <= item;
		if (state_q == S_OUT && out_free)
			result_q <= res_d;
	end

	`ACBF_ASSERT(a_accept_leaves_idle, (item_valid && !item_stall) |=> (state_q != S_IDLE), "accepted beat did not start work")
	`ACBF_ASSERT_IMPLY(a_pop_walk, (state_q == S_POP_HASH), (len_q != '0 && i_q <= len_q), "pop walk out of frame")
	`ACBF_ASSERT(a_result_source, $rose(result_valid_q) |-> $past(state_q == S_OUT), "result beat without finished work")

endmodule
